>>> src/bdc_pkg.sv
// Package for the bellows direction classifier.
// Holds the sequencer state type, the direction codes and the register map.
// No dependencies.
package bdc_pkg;

	// Result direction codes; the code three never appears and reads as neutral.
	typedef enum logic [1:0] {
		DIR_NEUTRAL = 2'd0,
		DIR_PUSH    = 2'd1,
		DIR_PULL    = 2'd2
	} dir_t;

	// Sequencer states of the classifier.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_CLASS,
		ST_SPAN,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	// Register port geometry and register indexes (byte address is 4 * index).
	localparam int unsigned CFG_ADDR_BITS = 5;
	localparam int unsigned CFG_DATA_BITS = 32;

	localparam logic [2:0] REG_CENTER    = 3'd0;
	localparam logic [2:0] REG_DEAD_BAND = 3'd1;
	localparam logic [2:0] REG_HYST      = 3'd2;
	localparam logic [2:0] REG_FULL_PUSH = 3'd3;
	localparam logic [2:0] REG_FULL_PULL = 3'd4;

endpackage

>>> src/bellows_direction_classifier.sv
// Bellows direction classifier top level: register block, sequencer and a
// shared restoring divider that scales the intensity.
// Depends on bdc_pkg.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+----------------------------------
//   s_*      | in  | s_tvalid / s_tready    | s_tdata: sample
//   m_*      | out | m_tvalid / m_tready    | m_tdata: direction, intensity
//   apb      | in  | psel, penable, pready  | paddr, pwdata, prdata
//
// An accepted request steps through the edge, classify, span and check states,
// then the divider loop unless the check settles it, and is loaded into the
// output register from done once the slot is free; the divider loop makes one
// quotient bit per cycle through a single subtract and compare. s_tready is high
// only while idle; a result waiting in the output register keeps the sequencer
// in done and so blocks the next request. Reset clears the registers to their
// documented values and the held direction to neutral; there is no clearing pass.
module bellows_direction_classifier
	import bdc_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS    = 24,
	parameter int unsigned INTENSITY_BITS = 10
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// Input stream.
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// [SAMPLE_BITS-1:0] sample, zero fill above
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,
	// Output stream.
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// [1:0] direction, [INTENSITY_BITS+2:2] intensity, zero fill above
	output logic [((INTENSITY_BITS + 10) / 8) * 8 - 1:0] m_tdata,
	// Configuration port.
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [CFG_ADDR_BITS-1:0]                  paddr,
	input  logic [CFG_DATA_BITS-1:0]                  pwdata,
	output logic [CFG_DATA_BITS-1:0]                  prdata,
	output logic                                      pready
);

	localparam int unsigned SB     = SAMPLE_BITS;
	localparam int unsigned UB     = SAMPLE_BITS - 1;
	localparam int unsigned EW     = SAMPLE_BITS + 3;
	localparam int unsigned QW     = INTENSITY_BITS;
	localparam int unsigned OW     = INTENSITY_BITS + 1;
	localparam int unsigned CW     = $clog2(INTENSITY_BITS);
	localparam int unsigned OUT_TW = ((INTENSITY_BITS + 10) / 8) * 8;

	// Configuration registers.
	logic signed [SB-1:0] center_q;
	logic        [UB-1:0] dead_band_q;
	logic        [UB-1:0] hysteresis_q;
	logic signed [SB-1:0] full_push_q;
	logic signed [SB-1:0] full_pull_q;

	// Sequencer and datapath registers.
	state_t               state_q, state_d;
	dir_t                 held_q;
	dir_t                 dir_q;
	logic signed [SB-1:0] sample_q;
	logic        [EW-1:0] half_q;
	logic signed [EW-1:0] push_edge_q;
	logic signed [EW-1:0] pull_edge_q;
	logic signed [EW-1:0] num_q;
	logic signed [EW-1:0] span_q;
	logic signed [EW-1:0] rem_q;
	logic        [OW-1:0] quot_q;
	logic        [CW-1:0] cnt_q;

	// Output register.
	logic                 out_valid_q;
	dir_t                 out_dir_q;
	logic        [OW-1:0] out_int_q;

	// Combinational helpers.
	logic                 cfg_we;
	logic                 in_take;
	logic                 out_free;
	logic signed [EW-1:0] x_e;
	logic signed [EW-1:0] hys_e;
	logic signed [EW-1:0] push_exit;
	logic signed [EW-1:0] pull_exit;
	logic signed [EW-1:0] div_diff;
	dir_t                 dir_new;

	assign pready   = 1'b1;
	assign cfg_we   = psel & penable & pwrite;
	assign in_take  = s_tvalid & s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Register writes; addresses beyond the map are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q     <= '0;
			dead_band_q  <= '0;
			hysteresis_q <= '0;
			full_push_q  <= {1'b1, {(SB - 1){1'b0}}};
			full_pull_q  <= {1'b0, {(SB - 1){1'b1}}};
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_CENTER:    center_q     <= pwdata[SB-1:0];
				REG_DEAD_BAND: dead_band_q  <= pwdata[UB-1:0];
				REG_HYST:      hysteresis_q <= pwdata[UB-1:0];
				REG_FULL_PUSH: full_push_q  <= pwdata[SB-1:0];
				REG_FULL_PULL: full_pull_q  <= pwdata[SB-1:0];
				default: ;
			endcase
		end
	end

	// Register read mux; signed registers read back sign extended.
	always_comb begin
		case (paddr[4:2])
			REG_CENTER:    prdata = CFG_DATA_BITS'(center_q);
			REG_DEAD_BAND: prdata = CFG_DATA_BITS'(dead_band_q);
			REG_HYST:      prdata = CFG_DATA_BITS'(hysteresis_q);
			REG_FULL_PUSH: prdata = CFG_DATA_BITS'(full_push_q);
			REG_FULL_PULL: prdata = CFG_DATA_BITS'(full_pull_q);
			default:       prdata = '0;
		endcase
	end

	// Exit thresholds for a held direction and the classification itself.
	assign x_e       = EW'(sample_q);
	assign hys_e     = $signed(EW'(hysteresis_q));
	assign push_exit = push_edge_q + hys_e;
	assign pull_exit = pull_edge_q - hys_e;

	always_comb begin
		case (held_q)
			DIR_PUSH: begin
				if (x_e > pull_edge_q)     dir_new = DIR_PULL;
				else if (x_e >= push_exit) dir_new = DIR_NEUTRAL;
				else                       dir_new = DIR_PUSH;
			end
			DIR_PULL: begin
				if (x_e < push_edge_q)     dir_new = DIR_PUSH;
				else if (x_e <= pull_exit) dir_new = DIR_NEUTRAL;
				else                       dir_new = DIR_PULL;
			end
			default: begin
				if (x_e < push_edge_q)      dir_new = DIR_PUSH;
				else if (x_e > pull_edge_q) dir_new = DIR_PULL;
				else                        dir_new = DIR_NEUTRAL;
			end
		endcase
	end

	// The shared subtractor of the restoring divider.
	assign div_diff = {rem_q[EW-2:0], 1'b0} - span_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_EDGE;
			end
			ST_EDGE:  state_d = ST_CLASS;
			ST_CLASS: state_d = ST_SPAN;
			ST_SPAN:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (span_q <= 0 || num_q >= span_q) state_d = ST_DONE;
				else                                state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CW'(QW - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Held direction: the only state carried from one request to the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= DIR_NEUTRAL;
		end else if (state_q == ST_CLASS) begin
			held_q <= dir_new;
		end
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= s_tdata[SB-1:0];
				half_q   <= EW'(dead_band_q[UB-1:1]) + EW'(hysteresis_q[UB-1:1]);
			end
			ST_EDGE: begin
				push_edge_q <= EW'(center_q) - $signed(half_q);
				pull_edge_q <= EW'(center_q) + $signed(half_q);
			end
			ST_CLASS: begin
				dir_q <= dir_new;
			end
			ST_SPAN: begin
				// Distance beyond the active edge and span to the full level.
				case (dir_q)
					DIR_PUSH: begin
						num_q  <= (x_e < push_edge_q) ? push_edge_q - x_e : '0;
						span_q <= push_edge_q - EW'(full_push_q);
					end
					DIR_PULL: begin
						num_q  <= (x_e > pull_edge_q) ? x_e - pull_edge_q : '0;
						span_q <= EW'(full_pull_q) - pull_edge_q;
					end
					default: begin
						num_q  <= '0;
						span_q <= '0;
					end
				endcase
			end
			ST_CHECK: begin
				rem_q <= num_q;
				cnt_q <= '0;
				if (span_q <= 0) begin
					quot_q <= '0;
				end else if (num_q >= span_q) begin
					quot_q <= {1'b1, {QW{1'b0}}};
				end else begin
					quot_q <= '0;
				end
			end
			ST_DIV: begin
				// One quotient bit per cycle.
				cnt_q <= cnt_q + CW'(1);
				if (!div_diff[EW-1]) begin
					rem_q  <= div_diff;
					quot_q <= {quot_q[OW-2:0], 1'b1};
				end else begin
					rem_q  <= {rem_q[EW-2:0], 1'b0};
					quot_q <= {quot_q[OW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Output register: loaded when the result is done and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_dir_q <= dir_q;
			out_int_q <= quot_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'({out_int_q, out_dir_q});

	// A request always starts the edge step in the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == ST_EDGE)
		else $error("accepted request did not start the sequencer");

	// Direction code three never leaves the block.
	a_dir_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_dir_q != 2'd3)
		else $error("invalid direction code on output");

	// A neutral result carries no intensity.
	a_neutral_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_dir_q == DIR_NEUTRAL) |-> out_int_q == '0)
		else $error("neutral result with nonzero intensity");

	// Intensity never exceeds full scale.
	a_int_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_int_q <= {1'b1, {QW{1'b0}}})
		else $error("intensity above full scale");

	// The divider only ever holds a remainder below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (rem_q >= 0 && rem_q < span_q))
		else $error("divider remainder out of range");

endmodule

>>> tb/bdc_direction_checker.sv
// Checker for the bellows direction classifier: follows register writes,
// predicts direction and intensity for each sample request and compares results.
// Depends on bdc_pkg.
module bdc_direction_checker
	import bdc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	// [23:0] sample
	input  logic [23:0]              s_tdata,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	// [1:0] direction, [12:2] intensity, [15:13] zero fill
	input  logic [15:0]              m_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output int                       mismatches,
	output int                       pending,
	output int                       results_seen
);

	localparam int     SAMPLE_BITS    = 24;
	localparam int     INTENSITY_BITS = 10;
	localparam int     PRINT_CAP      = 40;
	localparam longint FULL_SCALE     = longint'(1) << INTENSITY_BITS;
	localparam longint SAMPLE_MIN     = -(longint'(1) << (SAMPLE_BITS - 1));
	localparam longint SAMPLE_MAX     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

	typedef struct packed {
		dir_t                    dir;
		logic [INTENSITY_BITS:0] intensity;
	} reading_t;

	// Local copy of the register file and of the held direction.
	longint   center;
	longint   dead_band;
	longint   hysteresis;
	longint   push_full;
	longint   pull_full;
	dir_t     held;
	reading_t expected_readings[$];
	int       error_total;
	int       compared;

	// Distance beyond the edge scaled against the span to the full level.
	function automatic logic [INTENSITY_BITS:0] scale_intensity(input longint beyond,
			input longint span);
		if (span <= 0) begin
			return '0;
		end
		if (beyond >= span) begin
			return (INTENSITY_BITS + 1)'(FULL_SCALE);
		end
		return (INTENSITY_BITS + 1)'((beyond * FULL_SCALE) / span);
	endfunction

	// Three-level decision with hysteresis around the held direction.
	function automatic reading_t classify_sample(input logic [SAMPLE_BITS-1:0] raw,
			input dir_t prior);
		longint   x;
		longint   half;
		longint   push_lim;
		longint   pull_lim;
		reading_t r;
		x        = longint'(signed'(raw));
		half     = dead_band / 2 + hysteresis / 2;
		push_lim = center - half;
		pull_lim = center + half;
		case (prior)
			DIR_PUSH: begin
				if (x > pull_lim) r.dir = DIR_PULL;
				else if (x >= push_lim + hysteresis) r.dir = DIR_NEUTRAL;
				else r.dir = DIR_PUSH;
			end
			DIR_PULL: begin
				if (x < push_lim) r.dir = DIR_PUSH;
				else if (x <= pull_lim - hysteresis) r.dir = DIR_NEUTRAL;
				else r.dir = DIR_PULL;
			end
			default: begin
				if (x < push_lim) r.dir = DIR_PUSH;
				else if (x > pull_lim) r.dir = DIR_PULL;
				else r.dir = DIR_NEUTRAL;
			end
		endcase
		r.intensity = '0;
		if (r.dir == DIR_PUSH) begin
			r.intensity = scale_intensity((x < push_lim) ? push_lim - x : 0,
				push_lim - push_full);
		end else if (r.dir == DIR_PULL) begin
			r.intensity = scale_intensity((x > pull_lim) ? x - pull_lim : 0,
				pull_full - pull_lim);
		end
		return r;
	endfunction

	// Track writes, queue a prediction per request, compare each result.
	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		logic [1:0] got_dir;
		logic [INTENSITY_BITS:0] got_level;
		if (!arst_n) begin
			center      = 0;
			dead_band   = 0;
			hysteresis  = 0;
			push_full   = SAMPLE_MIN;
			pull_full   = SAMPLE_MAX;
			held        = DIR_NEUTRAL;
			expected_readings.delete();
			error_total = 0;
			compared    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_ADDR_BITS-1:2])
					REG_CENTER:    center     = longint'(signed'(pwdata[23:0]));
					REG_DEAD_BAND: dead_band  = longint'(pwdata[22:0]);
					REG_HYST:      hysteresis = longint'(pwdata[22:0]);
					REG_FULL_PUSH: push_full  = longint'(signed'(pwdata[23:0]));
					REG_FULL_PULL: pull_full  = longint'(signed'(pwdata[23:0]));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = classify_sample(s_tdata, held);
				held = want.dir;
				expected_readings.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got_dir   = m_tdata[1:0];
				got_level = m_tdata[INTENSITY_BITS+2:2];
				compared++;
				if (expected_readings.size() == 0) begin
					if (error_total < PRINT_CAP) begin
						$display("%0t: unexpected result dir %0d intensity %0d", $time,
							got_dir, got_level);
					end
					error_total++;
				end else begin
					want = expected_readings.pop_front();
					if (got_dir != want.dir || got_level != want.intensity) begin
						if (error_total < PRINT_CAP) begin
							$display("%0t: expected dir %0d intensity %0d, got dir %0d intensity %0d",
								$time, want.dir, want.intensity, got_dir, got_level);
						end
						error_total++;
					end
				end
			end
		end
		mismatches   <= error_total;
		pending      <= expected_readings.size();
		results_seen <= compared;
	end

endmodule

>>> tb/tb_top.sv
// Testbench top for the bellows direction classifier: clock, reset, register
// writes, sample stimulus with idle phases and the final verdict.
// Depends on bdc_pkg, bellows_direction_classifier and bdc_direction_checker.
module tb_top;
	import bdc_pkg::*;

	localparam int     HOLD_CYCLES     = 300;
	localparam int     WATCHDOG_LIMIT  = 5000;
	localparam int     DRAIN_CYCLES    = 40;
	localparam int     RANDOM_PHASES   = 12;
	localparam int     ITEMS_PER_PHASE = 85;
	localparam longint SAMPLE_MIN      = -(longint'(1) << 23);
	localparam longint SAMPLE_MAX      = (longint'(1) << 23) - 1;
	localparam longint BAND_MAX        = (longint'(1) << 23) - 1;
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam int     UNUSED_REGS     = 3;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	// [23:0] sample
	logic [23:0]              s_tdata  = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	// [1:0] direction, [12:2] intensity, [15:13] zero fill
	logic [15:0]              m_tdata;
	logic                     psel     = 1'b0;
	logic                     penable  = 1'b0;
	logic                     pwrite   = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr    = '0;
	logic [CFG_DATA_BITS-1:0] pwdata   = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	idle_mode_t idle_mode    = IDLE_NONE;
	int         hold_ticket  = 0;
	int         hold_taken   = 0;
	int         hold_left    = 0;
	int         quiet_cycles = 0;
	int         mismatches;
	int         pending;
	int         results_seen;

	// Register values as last written, used to aim samples at the edges.
	longint cfg_center    = 0;
	longint cfg_dead_band = 0;
	longint cfg_hyst      = 0;
	longint cfg_full_push = SAMPLE_MIN;
	longint cfg_full_pull = SAMPLE_MAX;
	int     samples_sent  = 0;
	int     settings_used = 1;

	initial begin
		forever #10 clk = ~clk;
	end

	bellows_direction_classifier u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	bdc_direction_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// Result side: random stalls per phase, plus a long hold when requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ticket != hold_taken) begin
			hold_taken <= hold_ticket;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (idle_mode == IDLE_RECV) begin
			m_tready <= ($urandom_range(0, 99) >= 74);
		end else if (idle_mode == IDLE_BOTH) begin
			m_tready <= ($urandom_range(0, 99) >= 27);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: ends the run after too many cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic longint clamp_sample(input longint v);
		if (v < SAMPLE_MIN) return SAMPLE_MIN;
		if (v > SAMPLE_MAX) return SAMPLE_MAX;
		return v;
	endfunction

	// One register write: a setup phase, the access phase until pready, then an idle gap.
	task automatic write_reg(input logic [2:0] idx, input longint value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input longint center, input longint dead_band,
			input longint hyst, input longint push_full, input longint pull_full);
		cfg_center    = clamp_sample(center);
		cfg_dead_band = dead_band;
		cfg_hyst      = hyst;
		cfg_full_push = clamp_sample(push_full);
		cfg_full_pull = clamp_sample(pull_full);
		write_reg(REG_CENTER, cfg_center);
		write_reg(REG_DEAD_BAND, cfg_dead_band);
		write_reg(REG_HYST, cfg_hyst);
		write_reg(REG_FULL_PUSH, cfg_full_push);
		write_reg(REG_FULL_PULL, cfg_full_pull);
		settings_used++;
	endtask

	// Offer one sample request, with random gaps in the idle phases.
	task automatic send_sample(input longint v);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SEND) ? 74 : (idle_mode == IDLE_BOTH) ? 27 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v[23:0];
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	// Stop offering and wait until every expected result has come back.
	// The wait first lets the checker's count take in the last request.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Mostly samples near the edges, the hysteresis points and the full levels.
	function automatic longint pick_sample();
		longint      half;
		longint      anchor;
		longint      spread;
		logic [23:0] raw;
		int unsigned sel;
		half = cfg_dead_band / 2 + cfg_hyst / 2;
		sel  = $urandom_range(0, 99);
		raw  = 24'($urandom);
		if (sel < 15) begin
			return longint'(signed'(raw));
		end
		if (sel < 25) begin
			case ($urandom_range(0, 3))
				0: return SAMPLE_MIN;
				1: return SAMPLE_MAX;
				2: return clamp_sample(cfg_full_push + longint'($urandom_range(0, 2)) - 1);
				default: return clamp_sample(cfg_full_pull + longint'($urandom_range(0, 2)) - 1);
			endcase
		end
		case ($urandom_range(0, 6))
			0: anchor = cfg_center - half;
			1: anchor = cfg_center - half + cfg_hyst;
			2: anchor = cfg_center + half;
			3: anchor = cfg_center + half - cfg_hyst;
			4: anchor = cfg_center;
			5: anchor = cfg_full_push;
			default: anchor = cfg_full_pull;
		endcase
		if ($urandom_range(0, 1) == 0) begin
			return clamp_sample(anchor + longint'($urandom_range(0, 6)) - 3);
		end
		spread = half + cfg_hyst + 64;
		if (spread > (longint'(1) << 22)) spread = longint'(1) << 22;
		return clamp_sample(anchor + longint'($urandom_range(0, 32'(2 * spread))) - spread);
	endfunction

	// Register settings of several kinds: random, extreme, realistic, plain.
	task automatic random_settings(input int kind);
		logic [23:0] raw_c;
		logic [23:0] raw_p;
		logic [23:0] raw_q;
		longint      c;
		longint      db;
		longint      hy;
		raw_c = 24'($urandom);
		raw_p = 24'($urandom);
		raw_q = 24'($urandom);
		case (kind)
			0: begin
				apply_settings(longint'(signed'(raw_c)), longint'($urandom_range(0, 32'(BAND_MAX))),
					longint'($urandom_range(0, 32'(BAND_MAX))), longint'(signed'(raw_p)),
					longint'(signed'(raw_q)));
				// Writes beyond the register map are ignored.
				for (int k = 0; k < UNUSED_REGS; k++) begin
					write_reg(REG_UNUSED_LO + 3'(k), longint'($urandom));
				end
			end
			1: begin
				apply_settings($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN,
					$urandom_range(0, 1) ? BAND_MAX : 0, BAND_MAX,
					$urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX,
					$urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
			end
			2: begin
				c  = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
				db = longint'($urandom_range(0, 4095));
				hy = longint'($urandom_range(0, 2047));
				apply_settings(c, db, hy,
					c - db / 2 - hy / 2 - longint'($urandom_range(0, 100000)) + 500,
					c + db / 2 + hy / 2 + longint'($urandom_range(0, 100000)) - 500);
			end
			default: begin
				c = longint'($urandom_range(0, 1 << 16)) - (1 << 15);
				apply_settings(c, 0, 0, c - longint'($urandom_range(1, 1024)),
					c + longint'($urandom_range(1, 1024)));
			end
		endcase
	endtask

	initial begin : stimulus
		int kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: extremes of the sample and the single threshold at zero.
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(0);
		send_sample(-1);
		send_sample(1);
		drain_results();

		// Push edge 870, pull edge 1130, hysteresis 60: cross every boundary,
		// hold each direction inside the hysteresis, jump straight across and saturate.
		apply_settings(1000, 200, 60, 0, 2000);
		send_sample(1000);
		send_sample(869);
		send_sample(900);
		send_sample(929);
		send_sample(930);
		send_sample(1131);
		send_sample(1100);
		send_sample(1070);
		send_sample(1130);
		send_sample(-5);
		send_sample(869);
		send_sample(1131);
		send_sample(5000);
		send_sample(869);
		drain_results();

		// Full levels on the wrong side of the edges: span not positive.
		apply_settings(1000, 200, 60, 900, 1130);
		send_sample(0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		drain_results();

		// Random phases over settings and idle patterns.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			kind = (phase + phase / 4) % 4;
			idle_mode <= idle_mode_t'(phase % 4);
			random_settings(kind);
			if (phase == 0) begin
				// Long result hold while requests keep coming: the block backs up.
				hold_ticket <= hold_ticket + 1;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_sample(pick_sample());
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d samples under %0d register settings with all idle patterns.",
			samples_sent, settings_used);
		$display("Compared %0d results; %0d mismatches, %0d left waiting.",
			results_seen, mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
